### hdl/component_to_rgb8_convert_assert.svh
`ifndef COMPONENT_TO_RGB8_CONVERT_ASSERT_SVH
`define COMPONENT_TO_RGB8_CONVERT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define C2RGB8_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define C2RGB8_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/c2rgb8_pkg.sv
package c2rgb8_pkg;

    localparam int MAX_PRECISION = 16;
    localparam int NUM_COMP      = 4;
    localparam int SAMPLE_W      = 17;
    localparam int PREC_W        = 5;
    localparam int LEVEL_W       = 8;
    localparam int CFG_IW        = 3;
    localparam int CFG_DW        = 5;

    // offset sample: sign-extended sample plus half range of the precision
    localparam int OFFS_W = ((MAX_PRECISION > SAMPLE_W) ? MAX_PRECISION : SAMPLE_W) + 1;

    // low-precision stretch: v*255/m as (v * 255 * ceil(2^24/m)) >> 24, exact for v <= m
    localparam int STRETCH_SHIFT = 24;
    localparam int STRETCH_K_W   = 32;
    localparam int STRETCH_V_W   = LEVEL_W - 1;
    localparam int STRETCH_P_W   = STRETCH_V_W + STRETCH_K_W;

    localparam logic [STRETCH_K_W-1:0] STRETCH_K1 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd0) / 64'd1));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K2 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd2) / 64'd3));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K3 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd6) / 64'd7));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K4 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd14) / 64'd15));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K5 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd30) / 64'd31));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K6 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd62) / 64'd63));
    localparam logic [STRETCH_K_W-1:0] STRETCH_K7 =
        STRETCH_K_W'(64'd255 * (((64'd1 << STRETCH_SHIFT) + 64'd126) / 64'd127));

    // BT.601 full-range, signed 2.16 fixed point (16 fraction bits)
    localparam int YC_K_W    = 18;
    localparam int YC_D_W    = 9;
    localparam int YC_PROD_W = YC_K_W + YC_D_W;
    localparam int YC_ACC_W  = YC_PROD_W + 1;
    localparam int YC_FRAC   = 16;

    localparam logic signed [YC_K_W-1:0] YC_R_CR = 18'sd91881;
    localparam logic signed [YC_K_W-1:0] YC_G_CB = 18'sd22554;
    localparam logic signed [YC_K_W-1:0] YC_G_CR = 18'sd46802;
    localparam logic signed [YC_K_W-1:0] YC_B_CB = 18'sd116130;
    localparam logic signed [YC_ACC_W-1:0] YC_ROUND = YC_ACC_W'(32768);
    localparam logic signed [YC_D_W-1:0] YC_CHROMA_MID = 9'sd128;

    localparam int CMYK_PROD_W = 2 * LEVEL_W;

    typedef enum logic [1:0] {
        CM_GRAY  = 2'd0,
        CM_RGB   = 2'd1,
        CM_YCBCR = 2'd2,
        CM_CMYK  = 2'd3
    } t_color_model;

    typedef enum logic [CFG_IW-1:0] {
        REG_COLOR_MODEL  = 3'd0,
        REG_ALPHA_ENABLE = 3'd1,
        REG_PREC_C0      = 3'd2,
        REG_PREC_C1      = 3'd3,
        REG_PREC_C2      = 3'd4,
        REG_PREC_C3      = 3'd5,
        REG_SIGNED_MASK  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        t_color_model                         color_model;
        logic                                 alpha_enable;
        logic [NUM_COMP-1:0][PREC_W-1:0]      precision;
        logic [NUM_COMP-1:0]                  signed_mask;
    } t_cfg;

    function automatic logic [STRETCH_K_W-1:0] stretch_mult(input logic [2:0] prec);
        logic [STRETCH_K_W-1:0] k;
        case (prec)
            3'd1:    k = STRETCH_K1;
            3'd2:    k = STRETCH_K2;
            3'd3:    k = STRETCH_K3;
            3'd4:    k = STRETCH_K4;
            3'd5:    k = STRETCH_K5;
            3'd6:    k = STRETCH_K6;
            3'd7:    k = STRETCH_K7;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

### hdl/c2rgb8_if.sv
interface c2rgb8_pix_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [c2rgb8_pkg::SAMPLE_W-1:0] sample_c0;
    logic signed [c2rgb8_pkg::SAMPLE_W-1:0] sample_c1;
    logic signed [c2rgb8_pkg::SAMPLE_W-1:0] sample_c2;
    logic signed [c2rgb8_pkg::SAMPLE_W-1:0] sample_c3;

    modport source (output valid, sample_c0, sample_c1, sample_c2, sample_c3, input ready);
    modport sink   (input valid, sample_c0, sample_c1, sample_c2, sample_c3, output ready);
endinterface

interface c2rgb8_pix_out_if;
    logic                            valid;
    logic                            ready;
    logic [c2rgb8_pkg::LEVEL_W-1:0]  red_or_gray;
    logic [c2rgb8_pkg::LEVEL_W-1:0]  green;
    logic [c2rgb8_pkg::LEVEL_W-1:0]  blue;
    logic [c2rgb8_pkg::LEVEL_W-1:0]  alpha;

    modport source (output valid, red_or_gray, green, blue, alpha, input ready);
    modport sink   (input valid, red_or_gray, green, blue, alpha, output ready);
endinterface

interface c2rgb8_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [c2rgb8_pkg::CFG_IW-1:0]  index;
    logic [c2rgb8_pkg::CFG_DW-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/c2rgb8_cfg.sv
module c2rgb8_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    c2rgb8_cfg_if.sink         i_cfg,
    output c2rgb8_pkg::t_cfg   o_cfg
);
    import c2rgb8_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_model  <= CM_RGB;
            r_cfg.alpha_enable <= 1'b0;
            r_cfg.precision    <= {NUM_COMP{PREC_W'(8)}};
            r_cfg.signed_mask  <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_COLOR_MODEL:  r_cfg.color_model  <= t_color_model'(i_cfg.data[1:0]);
                REG_ALPHA_ENABLE: r_cfg.alpha_enable <= i_cfg.data[0];
                REG_PREC_C0:      r_cfg.precision[0] <= i_cfg.data[PREC_W-1:0];
                REG_PREC_C1:      r_cfg.precision[1] <= i_cfg.data[PREC_W-1:0];
                REG_PREC_C2:      r_cfg.precision[2] <= i_cfg.data[PREC_W-1:0];
                REG_PREC_C3:      r_cfg.precision[3] <= i_cfg.data[PREC_W-1:0];
                REG_SIGNED_MASK:  r_cfg.signed_mask  <= i_cfg.data[NUM_COMP-1:0];
                default:          ;
            endcase
        end
    end

endmodule

### hdl/c2rgb8_level.sv
`include "component_to_rgb8_convert_assert.svh"

module c2rgb8_level (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  c2rgb8_pkg::t_cfg                                  i_cfg,
    c2rgb8_pix_in_if.sink                                     i_pix,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic [c2rgb8_pkg::NUM_COMP-1:0][c2rgb8_pkg::LEVEL_W-1:0] o_level
);
    import c2rgb8_pkg::*;

    logic [NUM_COMP-1:0][SAMPLE_W-1:0] samp;
    logic en1;
    logic en2;

    // stage 1: offset, shift to 8 bits, saturate
    logic                              r_vld1;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  r_v1;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  n_v1;
    logic [NUM_COMP-1:0][2:0]          r_p1;
    logic [NUM_COMP-1:0][2:0]          n_p1;
    logic [NUM_COMP-1:0]               r_low1;
    logic [NUM_COMP-1:0]               n_low1;

    // stage 2: stretch low precisions to full scale
    logic                              r_vld2;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  r_lvl2;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  n_lvl2;

    assign samp[0] = i_pix.sample_c0;
    assign samp[1] = i_pix.sample_c1;
    assign samp[2] = i_pix.sample_c2;
    assign samp[3] = i_pix.sample_c3;

    assign en2         = !r_vld2 || i_ready;
    assign en1         = !r_vld1 || en2;
    assign i_pix.ready = en1;
    assign o_valid     = r_vld2;
    assign o_level     = r_lvl2;

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        logic [PREC_W-1:0]        prec;
        logic [PREC_W-1:0]        shamt;
        logic signed [OFFS_W-1:0] x;
        logic [OFFS_W-1:0]        shifted;
        logic [LEVEL_W-1:0]       maxv;
        logic                     is_low;
        logic [STRETCH_P_W-1:0]   prod;

        always_comb begin
            prec = i_cfg.precision[c];
            if (prec == '0) begin
                prec = PREC_W'(1);
            end else if (prec > PREC_W'(MAX_PRECISION)) begin
                prec = PREC_W'(MAX_PRECISION);
            end
            x = OFFS_W'($signed(samp[c]));
            if (i_cfg.signed_mask[c]) begin
                x = x + (OFFS_W'(1) << (prec - PREC_W'(1)));
            end
            is_low  = prec < PREC_W'(LEVEL_W);
            shamt   = is_low ? '0 : prec - PREC_W'(LEVEL_W);
            shifted = x[OFFS_W-1] ? '0 : (OFFS_W'(x) >> shamt);
            maxv    = is_low ? ~(LEVEL_W'('1) << prec[2:0]) : '1;
            n_v1[c]   = (shifted > OFFS_W'(maxv)) ? maxv : shifted[LEVEL_W-1:0];
            n_p1[c]   = prec[2:0];
            n_low1[c] = is_low;
        end

        always_comb begin
            prod = STRETCH_P_W'(r_v1[c][STRETCH_V_W-1:0])
                 * STRETCH_P_W'(stretch_mult(r_p1[c]));
            n_lvl2[c] = r_low1[c] ? prod[STRETCH_SHIFT +: LEVEL_W] : r_v1[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (en1) begin
                r_vld1 <= i_pix.valid;
            end
            if (en2) begin
                r_vld2 <= r_vld1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_v1   <= n_v1;
            r_p1   <= n_p1;
            r_low1 <= n_low1;
        end
        if (en2) begin
            r_lvl2 <= n_lvl2;
        end
    end

    `C2RGB8_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_vld1 && !en2, r_vld1 && $stable(r_v1), "stage 1 beat lost on stall")
    `C2RGB8_ASSERT_NOW(a_s1_block, i_clk, i_rst_n, r_vld1 && r_vld2 && !i_ready, !i_pix.ready, "input taken while pipe full")

endmodule

### hdl/c2rgb8_color.sv
`include "component_to_rgb8_convert_assert.svh"

module c2rgb8_color (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  c2rgb8_pkg::t_cfg                                  i_cfg,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  logic [c2rgb8_pkg::NUM_COMP-1:0][c2rgb8_pkg::LEVEL_W-1:0] i_level,
    c2rgb8_pix_out_if.source                                  o_pix
);
    import c2rgb8_pkg::*;

    function automatic logic [LEVEL_W-1:0] clamp8(input logic signed [YC_ACC_W-1:0] v);
        logic [LEVEL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > YC_ACC_W'(255)) begin
            res = '1;
        end else begin
            res = v[LEVEL_W-1:0];
        end
        return res;
    endfunction

    // floor(x/255) for a 16-bit x of at most 255*255 (an 8-bit by 8-bit product)
    function automatic logic [LEVEL_W-1:0] div255(input logic [CMYK_PROD_W-1:0] x);
        logic [CMYK_PROD_W:0] t;
        t = (CMYK_PROD_W+1)'(x) + (CMYK_PROD_W+1)'(x[CMYK_PROD_W-1:LEVEL_W])
          + (CMYK_PROD_W+1)'(1);
        return t[CMYK_PROD_W-1:LEVEL_W];
    endfunction

    logic en3;
    logic en4;

    // stage 3: chroma and ink products
    logic                              r_vld3;
    t_color_model                      r_model3;
    logic                              r_alpha_en3;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  r_lvl3;
    logic signed [YC_PROD_W-1:0]       r_rcr3;
    logic signed [YC_PROD_W-1:0]       r_gcb3;
    logic signed [YC_PROD_W-1:0]       r_gcr3;
    logic signed [YC_PROD_W-1:0]       r_bcb3;
    logic [CMYK_PROD_W-1:0]            r_cr3;
    logic [CMYK_PROD_W-1:0]            r_cg3;
    logic [CMYK_PROD_W-1:0]            r_cb3;

    logic signed [YC_D_W-1:0]          cb;
    logic signed [YC_D_W-1:0]          cr;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  ink;
    logic signed [YC_PROD_W-1:0]       n_rcr3;
    logic signed [YC_PROD_W-1:0]       n_gcb3;
    logic signed [YC_PROD_W-1:0]       n_gcr3;
    logic signed [YC_PROD_W-1:0]       n_bcb3;
    logic [CMYK_PROD_W-1:0]            n_cr3;
    logic [CMYK_PROD_W-1:0]            n_cg3;
    logic [CMYK_PROD_W-1:0]            n_cb3;

    // stage 4: sums, clamp, model select
    logic                              r_vld4;
    logic [LEVEL_W-1:0]                r_red4;
    logic [LEVEL_W-1:0]                r_green4;
    logic [LEVEL_W-1:0]                r_blue4;
    logic [LEVEL_W-1:0]                r_alpha4;
    logic [LEVEL_W-1:0]                n_red4;
    logic [LEVEL_W-1:0]                n_green4;
    logic [LEVEL_W-1:0]                n_blue4;
    logic [LEVEL_W-1:0]                n_alpha4;

    logic signed [YC_ACC_W-1:0]        luma;
    logic signed [YC_ACC_W-1:0]        acc_r;
    logic signed [YC_ACC_W-1:0]        acc_g;
    logic signed [YC_ACC_W-1:0]        acc_b;

    assign en4     = !r_vld4 || o_pix.ready;
    assign en3     = !r_vld3 || en4;
    assign o_ready = en3;

    assign o_pix.valid       = r_vld4;
    assign o_pix.red_or_gray = r_red4;
    assign o_pix.green       = r_green4;
    assign o_pix.blue        = r_blue4;
    assign o_pix.alpha       = r_alpha4;

    always_comb begin
        cb     = $signed({1'b0, i_level[1]}) - YC_CHROMA_MID;
        cr     = $signed({1'b0, i_level[2]}) - YC_CHROMA_MID;
        n_rcr3 = YC_PROD_W'(cr) * YC_PROD_W'(YC_R_CR);
        n_gcb3 = YC_PROD_W'(cb) * YC_PROD_W'(YC_G_CB);
        n_gcr3 = YC_PROD_W'(cr) * YC_PROD_W'(YC_G_CR);
        n_bcb3 = YC_PROD_W'(cb) * YC_PROD_W'(YC_B_CB);
        // 255 - v is the bitwise complement for 8-bit levels
        ink    = ~i_level;
        n_cr3  = CMYK_PROD_W'(ink[0]) * CMYK_PROD_W'(ink[3]);
        n_cg3  = CMYK_PROD_W'(ink[1]) * CMYK_PROD_W'(ink[3]);
        n_cb3  = CMYK_PROD_W'(ink[2]) * CMYK_PROD_W'(ink[3]);
    end

    always_comb begin
        luma  = YC_ACC_W'($signed({1'b0, r_lvl3[0]}));
        acc_r = luma + ((YC_ACC_W'(r_rcr3) + YC_ROUND) >>> YC_FRAC);
        acc_g = luma - ((YC_ACC_W'(r_gcb3) + YC_ACC_W'(r_gcr3) + YC_ROUND) >>> YC_FRAC);
        acc_b = luma + ((YC_ACC_W'(r_bcb3) + YC_ROUND) >>> YC_FRAC);

        n_red4   = r_lvl3[0];
        n_green4 = r_lvl3[1];
        n_blue4  = r_lvl3[2];
        n_alpha4 = '1;
        case (r_model3)
            CM_GRAY: begin
                n_green4 = '0;
                n_blue4  = '0;
            end
            CM_RGB: begin
                if (r_alpha_en3) begin
                    n_alpha4 = r_lvl3[3];
                end
            end
            CM_YCBCR: begin
                n_red4   = clamp8(acc_r);
                n_green4 = clamp8(acc_g);
                n_blue4  = clamp8(acc_b);
            end
            CM_CMYK: begin
                n_red4   = div255(r_cr3);
                n_green4 = div255(r_cg3);
                n_blue4  = div255(r_cb3);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en3) begin
                r_vld3 <= i_valid;
            end
            if (en4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_model3    <= i_cfg.color_model;
            r_alpha_en3 <= i_cfg.alpha_enable;
            r_lvl3      <= i_level;
            r_rcr3      <= n_rcr3;
            r_gcb3      <= n_gcb3;
            r_gcr3      <= n_gcr3;
            r_bcb3      <= n_bcb3;
            r_cr3       <= n_cr3;
            r_cg3       <= n_cg3;
            r_cb3       <= n_cb3;
        end
        if (en4) begin
            r_red4   <= n_red4;
            r_green4 <= n_green4;
            r_blue4  <= n_blue4;
            r_alpha4 <= n_alpha4;
        end
    end

    `C2RGB8_ASSERT_NEXT(a_opaque, i_clk, i_rst_n, en4 && r_vld3 && r_model3 != CM_RGB, r_alpha4 == '1, "alpha not opaque outside rgb")
    `C2RGB8_ASSERT_NEXT(a_gray_zero, i_clk, i_rst_n, en4 && r_vld3 && r_model3 == CM_GRAY, r_green4 == '0 && r_blue4 == '0, "gray beat has color")

endmodule

### hdl/component_to_rgb8_convert.sv
// An accepted input beat passes four register stages on its way to o_pix
// (level scaling, low-precision stretch multiply, color products,
// sum/clamp/select), each with its own valid bit, so a stall on o_pix backs
// up without loss. Throughput: one pixel per cycle while o_pix does not stall.
// Reset (i_rst_n low, synchronous): pipeline emptied, config registers to defaults.
module component_to_rgb8_convert (
    input  logic          i_clk,
    input  logic          i_rst_n,
    c2rgb8_cfg_if.sink    i_cfg,
    c2rgb8_pix_in_if.sink i_pix,
    c2rgb8_pix_out_if.source o_pix
);
    import c2rgb8_pkg::*;

    t_cfg                              cfg;
    logic                              lvl_valid;
    logic                              lvl_ready;
    logic [NUM_COMP-1:0][LEVEL_W-1:0]  lvl;

    c2rgb8_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    c2rgb8_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (i_pix),
        .o_valid (lvl_valid),
        .i_ready (lvl_ready),
        .o_level (lvl)
    );

    c2rgb8_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (lvl_valid),
        .o_ready (lvl_ready),
        .i_level (lvl),
        .o_pix   (o_pix)
    );

endmodule
